[rtl/fdce_pkg.sv]
// shared constants, types and tables of the fixed-point to decimal text encoder
`default_nettype none

package fdce_pkg;

   // number format
   localparam int unsigned DECIMALS  = 3;
   localparam int unsigned FRAC_BITS = 16;

   // field widths
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned MAG_W    = 32;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DIGIT_W  = 4;

   // a 32-bit scaled magnitude has at most ten decimal places
   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
   localparam int unsigned WGT_W      = MAG_W + DIGIT_W;

   // elaboration-time power of ten
   function automatic longint unsigned pow10_const(input int unsigned n);
      longint unsigned p;
      p = 1;
      for (int unsigned i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   localparam longint unsigned SCALE   = pow10_const(DECIMALS);
   localparam int unsigned     SCALE_W = (SCALE > 1) ? $clog2(SCALE + 1) : 1;
   localparam int unsigned     PROD_W  = MAG_W + SCALE_W;

   // saturation bound on the magnitude and the scaled value printed then
   localparam longint unsigned LIMIT   = 64'h0000_0000_FFFF_FFFF / SCALE;
   localparam int unsigned     SAT_W   = MAG_W + FRAC_BITS;
   localparam logic [SAT_W-1:0]  SAT_MAG    = SAT_W'(LIMIT << FRAC_BITS);
   localparam logic [MAG_W-1:0]  SAT_SCALED = MAG_W'(LIMIT * SCALE);

   // rounding constant, half of one output unit
   localparam logic [PROD_W:0] ROUND_HALF =
      (FRAC_BITS > 0) ? (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1)) : '0;

   // weight of each decimal place
   typedef logic [NUM_DIGITS-1:0][WGT_W-1:0] pow_tab_type;

   function automatic pow_tab_type make_pow_tab();
      pow_tab_type tab;
      for (int unsigned i = 0; i < NUM_DIGITS; i++) begin
         tab[i] = WGT_W'(pow10_const(i));
      end
      return tab;
   endfunction

   localparam pow_tab_type POW10_TAB = make_pow_tab();

   // characters
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   // output byte select codes
   localparam logic [2:0] SEL_MINUS = 3'd0;
   localparam logic [2:0] SEL_DIGIT = 3'd1;
   localparam logic [2:0] SEL_DOT   = 3'd2;
   localparam logic [2:0] SEL_ZERO  = 3'd3;
   localparam logic [2:0] SEL_TERM  = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       load_rem;
      logic       step;
      logic       emit;
      logic [2:0] sel;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic nf;
      logic neg;
      logic out_free;
      logic show_digit;
      logic pos_zero;
      logic pos_units;
   } status_type;

endpackage

`default_nettype wire

[rtl/fdce_if.sv]
// valid/ready channel interfaces for sample beats and text byte beats
`default_nettype none

interface fdce_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               not_finite;
   logic               end_of_frame;

   modport source (output valid, output sample, output not_finite, output end_of_frame,
                   input ready);
   modport sink   (input valid, input sample, input not_finite, input end_of_frame,
                   output ready);
endinterface

interface fdce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_byte;
   logic       item_done;

   modport source (output valid, output ascii_byte, output item_done, input ready);
   modport sink   (input valid, input ascii_byte, input item_done, output ready);
endinterface

`default_nettype wire

[rtl/fdce_dp.sv]
// datapath: magnitude, scaling, decimal place scan and output byte register
`default_nettype none

module fdce_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fdce_pkg::cmd_type   cmd,
   output fdce_pkg::status_type     stat,
   input  wire logic signed [31:0]  sample,
   input  wire logic                not_finite,
   input  wire logic                end_of_frame,
   output logic                     out_valid,
   output logic [7:0]               out_byte,
   output logic                     out_done,
   input  wire logic                out_ready
);
   import fdce_pkg::*;

   logic [MAG_W-1:0]  mag_ff;
   logic              neg_ff, nf_ff, eof_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              sat_ff;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  pos_ff;
   logic              started_ff;
   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              done_ff;

   logic [MAG_W-1:0]   raw;
   logic [MAG_W-1:0]   mag_in;
   logic [PROD_W:0]    round_sum;
   logic [PROD_W:0]    round_shift;
   logic [WGT_W-1:0]   weight;
   logic [WGT_W-1:0]   mult [0:9];
   logic [WGT_W-1:0]   rem_ext;
   logic [DIGIT_W-1:0] digit;
   logic               out_free;

   // two's complement magnitude, the most negative value maps to 2^31
   assign raw    = MAG_W'(sample);
   assign mag_in = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;

   // sample capture on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff <= mag_in;
         neg_ff <= raw[MAG_W-1];
         nf_ff  <= not_finite;
         eof_ff <= end_of_frame;
      end
   end

   // scale by ten to the number of decimals, flag saturation
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mag_ff) * PROD_W'(SCALE);
      sat_ff  <= SAT_W'(mag_ff) > SAT_MAG;
   end

   // round half up and drop the fraction bits
   assign round_sum   = {1'b0, prod_ff} + ROUND_HALF;
   assign round_shift = round_sum >> FRAC_BITS;

   // multiples of the current place weight, pick the largest that fits
   assign weight  = POW10_TAB[pos_ff];
   assign rem_ext = WGT_W'(rem_ff);

   always_comb begin
      digit = '0;
      for (int d = 0; d < 10; d++) begin
         mult[d] = WGT_W'(weight * WGT_W'(d));
      end
      for (int d = 1; d < 10; d++) begin
         if (rem_ext >= mult[d]) begin
            digit = DIGIT_W'(d);
         end
      end
   end

   assign rem_in = rem_ff - MAG_W'(mult[digit]);

   // decimal place scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pos_ff     <= '0;
      end else if (cmd.load_rem) begin
         started_ff <= 1'b0;
         pos_ff     <= POS_W'(NUM_DIGITS - 1);
      end else if (cmd.step) begin
         started_ff <= started_ff | (digit != '0);
         pos_ff     <= pos_ff - POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rem) begin
         rem_ff <= sat_ff ? SAT_SCALED : round_shift[MAG_W-1:0];
      end else if (cmd.step) begin
         rem_ff <= rem_in;
      end
   end

   // byte selection
   always_comb begin
      case (cmd.sel)
         SEL_MINUS: byte_in = CH_MINUS;
         SEL_DIGIT: byte_in = CH_ZERO + BYTE_W'(digit);
         SEL_DOT:   byte_in = CH_DOT;
         SEL_ZERO:  byte_in = CH_ZERO;
         SEL_TERM:  byte_in = eof_ff ? CH_LF : CH_COMMA;
         default:   byte_in = CH_ZERO;
      endcase
   end

   // output beat register
   assign out_free = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         byte_ff <= byte_in;
         done_ff <= (cmd.sel == SEL_TERM);
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_done  = done_ff;

   // status to the controller
   assign stat.nf         = nf_ff;
   assign stat.neg        = neg_ff;
   assign stat.out_free   = out_free;
   assign stat.show_digit = (digit != '0) || started_ff || (pos_ff <= POS_W'(DECIMALS));
   assign stat.pos_zero   = (pos_ff == '0);
   assign stat.pos_units  = (pos_ff == POS_W'(DECIMALS));

   // the digit removed never exceeds the remainder
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rem_ext >= mult[digit]))
      else $error("digit weight exceeds remainder");

   // every place from the units down is printed
   assert property (@(posedge clock) disable iff (reset)
      cmd.step && (pos_ff <= POS_W'(DECIMALS)) |-> cmd.emit)
      else $error("place at or below units skipped");

   // a beat is never overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |-> !cmd.emit)
      else $error("pending beat overwritten");

endmodule

`default_nettype wire

[rtl/fdce_ctrl.sv]
// controller: sequences sign, decimal places, point and terminator per sample, or a zero and terminator when not finite
`default_nettype none

module fdce_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire fdce_pkg::status_type  stat,
   output fdce_pkg::cmd_type          cmd
);
   import fdce_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_DIGIT = 3'd3;
   localparam logic [2:0] ST_DOT   = 3'd4;
   localparam logic [2:0] ST_ZERO  = 3'd5;
   localparam logic [2:0] ST_TERM  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign in_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.load_rem = 1'b0;
      cmd.step     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.sel      = SEL_DIGIT;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = stat.nf ? ST_ZERO : ST_SIGN;
         end
         ST_SIGN: begin
            cmd.load_rem = 1'b1;
            cmd.sel      = SEL_MINUS;
            if (!stat.neg) begin
               state_in = ST_DIGIT;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.sel = SEL_DIGIT;
            if (!stat.show_digit || stat.out_free) begin
               cmd.step = 1'b1;
               cmd.emit = stat.show_digit;
               if (stat.pos_zero) begin
                  state_in = ST_TERM;
               end else if (stat.pos_units) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            cmd.sel = SEL_DOT;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_ZERO: begin
            cmd.sel = SEL_ZERO;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            cmd.sel = SEL_TERM;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a beat is only launched into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("beat launched into busy output");

   // the last place always leads to the terminator
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) && cmd.step && stat.pos_zero |=> (state_ff == ST_TERM))
      else $error("terminator missed after last place");

   // the point follows the units place when there are decimals
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) && cmd.step && stat.pos_units && !stat.pos_zero
      |=> (state_ff == ST_DOT))
      else $error("decimal point missed");

   // an accepted sample always starts the load cycle
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> (state_ff == ST_LOAD))
      else $error("accepted sample not loaded");

endmodule

`default_nettype wire

[rtl/fixed_to_decimal_csv_encoder.sv]
// top level of the fixed-point to decimal text encoder
`default_nettype none

// Prints one signed Q16.16 sample per accepted beat as text, one character per
// output beat: an optional '-', the integer digits without leading zeros, '.'
// and three fraction digits (rounded half up, magnitude saturated), then ','
// or, with end_of_frame set, a newline; either terminator carries item_done. A
// not-finite sample prints a single '0' and its terminator. Samples are handled
// one at a time: a finite sample occupies the block through accept, multiply,
// sign, the scan of all ten decimal places (one place per cycle while the
// output is free or the place is not printed), point and terminator; a
// not-finite one through accept, load, zero and terminator. Output stalls hold
// the block in any step that has a character to send.
module fixed_to_decimal_csv_encoder (
   input  wire logic  clock,
   input  wire logic  reset,
   fdce_req_if.sink   req_bus,
   fdce_rsp_if.source rsp_bus
);
   import fdce_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       in_ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       out_done;

   // sequencing
   fdce_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (in_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // arithmetic and output register
   fdce_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .sample       (req_bus.sample),
      .not_finite   (req_bus.not_finite),
      .end_of_frame (req_bus.end_of_frame),
      .out_valid    (out_valid),
      .out_byte     (out_byte),
      .out_done     (out_done),
      .out_ready    (rsp_bus.ready)
   );

   // channel hookup
   assign req_bus.ready      = in_ready;
   assign rsp_bus.valid      = out_valid;
   assign rsp_bus.ascii_byte = out_byte;
   assign rsp_bus.item_done  = out_done;

endmodule

`default_nettype wire
